FILE: sv/wis_pkg.sv
// Shared constants, codes and controller/datapath interface types for the weighted index selector.
package wis_pkg;

  // Default table depth
  localparam int unsigned WIS_CAPACITY = 64;

  // Q1.16 probability format, 65536 is 1.0
  localparam int unsigned Q16_W   = 17;
  localparam int unsigned ONE_Q16 = 65536;

  // Field widths
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned DRAW_W   = 7;
  localparam int unsigned ENTRY_W  = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CHOSEN_W = 6;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 32;

  // Serial divider steps, one quotient bit each
  localparam int unsigned DIV_STEPS = Q16_W;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS + 1);

  // Item modes
  localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DRAW = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOMATCH = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_RANGE   = 2'd3;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_SUM,
    S_DIV,
    S_SEL,
    S_READ,
    S_FIN
  } wis_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_in;    // capture the input word
    logic clr_pass;   // clear pointer, sums and match flags
    logic add_do;     // append one entry
    logic sum_run;    // sum pass over the table
    logic div_start;  // load divider with the remainder
    logic div_run;    // one divider step
    logic sel_start;  // rewind pointer for the select pass
    logic sel_run;    // resolve and select pass over the table
    logic read_do;    // read one entry
    logic out_load;   // load the result into the output register
  } wis_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic pass_done;
    logic div_done;
    logic out_free;
  } wis_sts_t;

endpackage

FILE: sv/weighted_index_selector_unit.sv
// Top level of the weighted index selector: roulette-wheel draw over a Q1.16 weight table.
//
//  channel   | dir | handshake             | contents
//  ----------+-----+-----------------------+------------------------------------------
//  s_axis    | in  | tvalid/tready         | one item word: mode, weight, flag, draw, index
//  m_axis    | out | tvalid/tready         | one result word per item: status, index, weight
//
// A draw makes one table sweep to sum known weights, 17 divider steps for the
// share, then one sweep to resolve and select, each sweep bound by the single
// read port of the table RAM.
// Reset clears the entry count; the table needs no clearing pass.
// One item is in flight at a time; a finished word waits in the output register
// and the next item is accepted meanwhile, stalling only at its own result.
module weighted_index_selector_unit
  import wis_pkg::*;
#(
  parameter int unsigned CAPACITY = WIS_CAPACITY
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [16:0] weight, [17] auto_share, [24:18] draw_value, [30:25] entry_index
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [1:0] mode
  input  logic [MODE_W-1:0]      s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [1:0] status, [7:2] chosen_index, [24:8] weight_out
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  wis_cmd_t cmd;
  wis_sts_t sts;

  wis_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_mode_i (s_axis_tuser_i),
    .in_ready_o(s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  wis_dpath #(
    .CAPACITY(CAPACITY)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (s_axis_tdata_i),
    .in_mode_i  (s_axis_tuser_i),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o (m_axis_tdata_o)
  );

endmodule

FILE: sv/wis_ram.sv
// Generic simple dual-port RAM with registered read.
module wis_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/wis_ctrl.sv
// Controller state machine sequencing add, draw and read items.
module wis_ctrl
  import wis_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [MODE_W-1:0] in_mode_i,
  output logic              in_ready_o,
  input  wis_sts_t          sts_i,
  output wis_cmd_t          cmd_o
);

  wis_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_mode_i)
            MODE_ADD:  state_d = S_ADD;
            MODE_DRAW: state_d = S_SUM;
            MODE_READ: state_d = S_READ;
            default:   state_d = S_FIN;
          endcase
        end
      end
      S_ADD:  state_d = S_FIN;
      S_SUM: begin
        if (sts_i.pass_done) state_d = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) state_d = S_SEL;
      end
      S_SEL: begin
        if (sts_i.pass_done) state_d = S_FIN;
      end
      S_READ: state_d = S_FIN;
      S_FIN: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in  = 1'b1;
          cmd_o.clr_pass = 1'b1;
        end
      end
      S_ADD: cmd_o.add_do = 1'b1;
      S_SUM: begin
        cmd_o.sum_run = 1'b1;
        if (sts_i.pass_done) cmd_o.div_start = 1'b1;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.sel_start = 1'b1;
        end else begin
          cmd_o.div_run = 1'b1;
        end
      end
      S_SEL:  cmd_o.sel_run = 1'b1;
      S_READ: cmd_o.read_do = 1'b1;
      S_FIN:  cmd_o.out_load = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

FILE: sv/wis_dpath.sv
// Datapath: weight table, sum and select passes, serial divider, result register.
module wis_dpath
  import wis_pkg::*;
#(
  parameter int unsigned CAPACITY = WIS_CAPACITY
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  wis_cmd_t               cmd_i,
  output wis_sts_t               sts_o,
  input  logic [IN_TDATA_W-1:0]  in_data_i,
  input  logic [MODE_W-1:0]      in_mode_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_data_o
);

  localparam int unsigned IDX_W  = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned ENT_W  = Q16_W + 1;
  localparam int unsigned SUM_W  = Q16_W + CNT_W;
  localparam int unsigned PROD_W = SUM_W + CNT_W;
  localparam int unsigned SCL_W  = PROD_W - 16;
  localparam int unsigned CMP_W  = (SCL_W > DRAW_W) ? SCL_W : DRAW_W;
  localparam int unsigned EW     = (CNT_W > ENTRY_W) ? CNT_W : ENTRY_W;
  localparam int unsigned CH_W   = (IDX_W > CHOSEN_W) ? IDX_W : CHOSEN_W;
  localparam int unsigned PAD_W  = OUT_TDATA_W - Q16_W - CHOSEN_W - STATUS_W;

  // Captured input word
  logic [MODE_W-1:0]  mode_q;
  logic [Q16_W-1:0]   weight_q;
  logic               auto_q;
  logic [DRAW_W-1:0]  draw_q;
  logic [ENTRY_W-1:0] eidx_q;

  // Table and pass state
  logic [CNT_W-1:0]  cnt_q, ptr_q;
  logic              full_q;
  logic              rd_vld_q;
  logic [IDX_W-1:0]  rd_idx_q;
  logic [SUM_W-1:0]  known_q, cum_q;
  logic [CNT_W-1:0]  marked_q;
  logic              cmp_vld_q;
  logic [IDX_W-1:0]  cmp_idx_q;
  logic              found_q;
  logic [IDX_W-1:0]  chosen_q;

  // Divider
  logic [Q16_W-1:0]  quo_q;
  logic [CNT_W-1:0]  rem_q;
  logic [DCNT_W-1:0] dcnt_q;

  // Output register
  logic                   m_vld_q;
  logic [OUT_TDATA_W-1:0] m_data_q;

  // RAM ports
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;

  logic             issue;
  logic             full;
  logic             in_range;
  logic [EW-1:0]    eidx_ext;
  logic             ent_pend;
  logic [Q16_W-1:0] ent_w, sel_w, sat_w;
  logic [SUM_W-1:0] rest_full;
  logic [Q16_W-1:0] rest;
  logic [CNT_W:0]   trial, trial_sub;
  logic             ge;
  logic [PROD_W-1:0] prod;
  logic [SCL_W-1:0]  scaled;
  logic              hit;
  logic [STATUS_W-1:0] res_status;
  logic [CHOSEN_W-1:0] res_chosen;
  logic [Q16_W-1:0]    res_wout;
  logic [CH_W-1:0]     chosen_ext;

  wis_ram #(
    .WIDTH(ENT_W),
    .DEPTH(CAPACITY)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Entry layout: pending mark above the Q1.16 weight
  assign ent_pend = ram_rdata[Q16_W];
  assign ent_w    = ram_rdata[Q16_W-1:0];

  // Decode helpers
  assign full     = (cnt_q >= CNT_W'(CAPACITY));
  assign eidx_ext = EW'(eidx_q);
  assign in_range = (eidx_ext < EW'(cnt_q));
  assign sat_w    = (weight_q > Q16_W'(ONE_Q16)) ? Q16_W'(ONE_Q16) : weight_q;
  assign issue    = (cmd_i.sum_run || cmd_i.sel_run) && (ptr_q != cnt_q);
  assign sel_w    = ent_pend ? quo_q : ent_w;

  // Read port: pass pointer or read item index
  assign ram_re    = issue || (cmd_i.read_do && in_range);
  assign ram_raddr = issue ? ptr_q[IDX_W-1:0] : eidx_ext[IDX_W-1:0];

  // Write port: append, or resolve a marked entry during the select pass
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_idx_q;
    ram_wdata = {1'b0, quo_q};
    if (cmd_i.add_do) begin
      ram_we    = !full;
      ram_waddr = cnt_q[IDX_W-1:0];
      ram_wdata = auto_q ? {1'b1, {Q16_W{1'b0}}} : {1'b0, sat_w};
    end else if (cmd_i.sel_run && rd_vld_q && ent_pend) begin
      ram_we = 1'b1;
    end
  end

  // Remainder left for marked entries
  assign rest_full = SUM_W'(ONE_Q16) - known_q;
  assign rest      = (known_q < SUM_W'(ONE_Q16)) ? rest_full[Q16_W-1:0] : '0;

  // Restoring divider step
  assign trial     = {rem_q, quo_q[Q16_W-1]};
  assign ge        = (trial >= {1'b0, marked_q});
  assign trial_sub = trial - {1'b0, marked_q};

  // Scaled cumulative weight compare
  assign prod   = PROD_W'(cum_q) * PROD_W'(CAPACITY);
  assign scaled = prod[PROD_W-1:16];
  assign hit    = cmp_vld_q && !found_q && (CMP_W'(draw_q) <= CMP_W'(scaled));

  // Input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q   <= in_mode_i;
      weight_q <= in_data_i[16:0];
      auto_q   <= in_data_i[17];
      draw_q   <= in_data_i[24:18];
      eidx_q   <= in_data_i[30:25];
    end
  end

  // Control state of table and passes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      ptr_q     <= '0;
      rd_vld_q  <= 1'b0;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
      dcnt_q    <= '0;
      m_vld_q   <= 1'b0;
    end else begin
      if (cmd_i.add_do && !full) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.clr_pass || cmd_i.sel_start) begin
        ptr_q <= '0;
      end else if (issue) begin
        ptr_q <= ptr_q + 1'b1;
      end
      rd_vld_q  <= issue;
      cmp_vld_q <= cmd_i.sel_run && rd_vld_q;
      if (cmd_i.clr_pass) begin
        found_q <= 1'b0;
      end else if (hit) begin
        found_q <= 1'b1;
      end
      if (cmd_i.div_start) begin
        dcnt_q <= '0;
      end else if (cmd_i.div_run) begin
        dcnt_q <= dcnt_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        m_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  // Sums, divider and match payload
  always_ff @(posedge clk_i) begin
    rd_idx_q  <= ptr_q[IDX_W-1:0];
    cmp_idx_q <= rd_idx_q;
    if (cmd_i.add_do) begin
      full_q <= full;
    end
    if (cmd_i.clr_pass) begin
      known_q  <= '0;
      marked_q <= '0;
      cum_q    <= '0;
    end else begin
      if (cmd_i.sum_run && rd_vld_q) begin
        if (ent_pend) begin
          marked_q <= marked_q + 1'b1;
        end else begin
          known_q <= known_q + SUM_W'(ent_w);
        end
      end
      if (cmd_i.sel_run && rd_vld_q) begin
        cum_q <= cum_q + SUM_W'(sel_w);
      end
    end
    if (hit) begin
      chosen_q <= cmp_idx_q;
    end
    if (cmd_i.div_start) begin
      quo_q <= rest;
      rem_q <= '0;
    end else if (cmd_i.div_run) begin
      quo_q <= {quo_q[Q16_W-2:0], ge};
      rem_q <= ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  // Result word
  assign chosen_ext = CH_W'(chosen_q);

  always_comb begin
    res_status = STAT_OK;
    res_chosen = '0;
    res_wout   = '0;
    unique case (mode_q)
      MODE_ADD: begin
        res_status = full_q ? STAT_FULL : STAT_OK;
      end
      MODE_DRAW: begin
        if (found_q) begin
          res_chosen = chosen_ext[CHOSEN_W-1:0];
        end else begin
          res_status = STAT_NOMATCH;
        end
      end
      MODE_READ: begin
        if (in_range) begin
          res_wout = ent_pend ? '0 : ent_w;
        end else begin
          res_status = STAT_RANGE;
        end
      end
      default: res_status = STAT_OK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      m_data_q <= {{PAD_W{1'b0}}, res_wout, res_chosen, res_status};
    end
  end

  assign out_valid_o = m_vld_q;
  assign out_data_o  = m_data_q;

  // Status to controller
  assign sts_o.pass_done = (ptr_q == cnt_q) && !rd_vld_q && !cmp_vld_q;
  assign sts_o.div_done  = (dcnt_q == DCNT_W'(DIV_STEPS));
  assign sts_o.out_free  = !m_vld_q || out_ready_i;

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_rd_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (CNT_W'(rd_idx_q) < cnt_q))
    else $error("pass read beyond filled entries");

  a_found_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(found_q) |-> (CNT_W'(chosen_q) < cnt_q))
    else $error("chosen index beyond filled entries");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dcnt_q <= DCNT_W'(DIV_STEPS))
    else $error("divider ran past its last step");

endmodule

FILE: sim/wis_result_checker.sv
// Result checker for the weighted index selector: predicts each result word and compares.
module wis_result_checker
  import wis_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // item channel, as seen at the block's slave side
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  // [16:0] weight, [17] auto_share, [24:18] draw_value, [30:25] entry_index
  input  logic [IN_TDATA_W-1:0]  in_data_i,
  // [1:0] mode
  input  logic [MODE_W-1:0]      in_mode_i,
  // result channel, as seen at the block's master side
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  // [1:0] status, [7:2] chosen_index, [24:8] weight_out
  input  logic [OUT_TDATA_W-1:0] out_data_i,
  output int                     mismatch_count_o,
  output int                     words_pending_o
);

  localparam int unsigned RES_W = Q16_W + CHOSEN_W + STATUS_W;

  // One result word, lowest field last
  typedef struct packed {
    logic [Q16_W-1:0]    weight;
    logic [CHOSEN_W-1:0] index;
    logic [STATUS_W-1:0] status;
  } sel_result_t;

  // Shadow copy of the block's table
  logic [Q16_W-1:0] weight_tab [WIS_CAPACITY];
  bit               share_mark [WIS_CAPACITY];
  int unsigned      entries;

  // Results owed by the block, oldest first
  sel_result_t      owed_q[$];

  // Work out the result of one item and update the shadow table
  task automatic predict_selection(input logic [MODE_W-1:0] mode,
                                   input logic [IN_TDATA_W-1:0] word,
                                   output sel_result_t res);
    logic [Q16_W-1:0]   w;
    logic               mark;
    logic [DRAW_W-1:0]  draw;
    logic [ENTRY_W-1:0] idx;
    longint unsigned    known;
    longint unsigned    cum;
    int unsigned        marked;
    int unsigned        rest;
    int unsigned        share;
    int unsigned        i;
    bit                 found;
    w     = word[Q16_W-1:0];
    mark  = word[Q16_W];
    draw  = word[Q16_W+1 +: DRAW_W];
    idx   = word[Q16_W+1+DRAW_W +: ENTRY_W];
    res   = '0;
    case (mode)
      MODE_ADD: begin
        if (entries >= WIS_CAPACITY) begin
          res.status = STAT_FULL;
        end else begin
          // weights above one saturate
          if (w > ONE_Q16) w = Q16_W'(ONE_Q16);
          weight_tab[entries] = mark ? '0 : w;
          share_mark[entries] = mark;
          entries++;
        end
      end
      MODE_DRAW: begin
        // resolve marked entries to an equal share of what is left
        known  = 0;
        marked = 0;
        rest   = 0;
        share  = 0;
        for (i = 0; i < entries; i++) begin
          if (share_mark[i]) marked++;
          else known += weight_tab[i];
        end
        if (known < ONE_Q16) rest = 32'(ONE_Q16 - known);
        if (rest > 0 && marked > 0) share = rest / marked;
        for (i = 0; i < entries; i++) begin
          if (share_mark[i]) begin
            weight_tab[i] = Q16_W'(share);
            share_mark[i] = 1'b0;
          end
        end
        // first index whose scaled running sum reaches the draw
        cum   = 0;
        found = 1'b0;
        for (i = 0; i < entries && !found; i++) begin
          cum += weight_tab[i];
          if (draw <= ((cum * WIS_CAPACITY) >> 16)) begin
            res.index = CHOSEN_W'(i);
            found     = 1'b1;
          end
        end
        if (!found) res.status = STAT_NOMATCH;
      end
      MODE_READ: begin
        if (idx >= entries) res.status = STAT_RANGE;
        else res.weight = share_mark[idx] ? '0 : weight_tab[idx];
      end
      default: begin
        // unused mode: all fields stay zero
      end
    endcase
  endtask

  // Watch both channels on every edge
  always @(posedge clk_i or negedge rst_ni) begin
    sel_result_t want;
    sel_result_t got;
    int          push;
    int          pop;
    int          errs;
    if (!rst_ni) begin
      for (int k = 0; k < WIS_CAPACITY; k++) begin
        weight_tab[k] = '0;
        share_mark[k] = 1'b0;
      end
      entries = 0;
      owed_q.delete();
      mismatch_count_o <= 0;
      words_pending_o  <= 0;
    end else begin
      push = 0;
      pop  = 0;
      errs = 0;
      if (out_valid_i && out_ready_i) begin
        got = sel_result_t'(out_data_i[RES_W-1:0]);
        if (owed_q.size() == 0) begin
          $display("%0t: result word %h arrived with no item waiting", $time, out_data_i);
          errs++;
        end else begin
          want = owed_q.pop_front();
          pop  = 1;
          if (got.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, got.status);
            errs++;
          end
          if (got.index !== want.index) begin
            $display("%0t: chosen_index mismatch: expected %0d, actual %0d",
                     $time, want.index, got.index);
            errs++;
          end
          if (got.weight !== want.weight) begin
            $display("%0t: weight_out mismatch: expected %0d, actual %0d",
                     $time, want.weight, got.weight);
            errs++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_selection(in_mode_i, in_data_i, want);
        owed_q.push_back(want);
        push = 1;
      end
      words_pending_o  <= words_pending_o + push - pop;
      mismatch_count_o <= mismatch_count_o + errs;
    end
  end

endmodule

FILE: sim/testbench.sv
// Top of the weighted index selector bench: clock, reset, stimulus, back pressure and verdict.
module testbench;
  import wis_pkg::*;

  localparam int                WATCHDOG_LIMIT = 4000;
  localparam int                HOLD_AT        = 700;   // result count that starts the long stall
  localparam int                HOLD_LEN       = 600;
  localparam int                PHASE_ITEMS    = 470;
  localparam int                DRAIN_CYCLES   = 200;
  localparam int                SMALL_W_MAX    = 2000;
  localparam int                WIDE_ADDS_FROM = 52;    // large weights only near the top
  localparam logic [MODE_W-1:0] MODE_UNUSED    = 2'd3;

  logic                   clk;
  logic                   rst_n;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [MODE_W-1:0]      s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int mismatches;
  int pending;
  int snd_idle_pct;
  int rcv_idle_pct;
  int adds_sent;

  weighted_index_selector_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  wis_result_checker result_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_i       (s_axis_tready),
    .in_data_i        (s_axis_tdata),
    .in_mode_i        (s_axis_tuser),
    .out_valid_i      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_data_i       (m_axis_tdata),
    .mismatch_count_o (mismatches),
    .words_pending_o  (pending)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off that backs the block up
  initial begin : receiver
    int seen;
    seen = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) seen++;
      if (seen == HOLD_AT) begin
        seen++;
        m_axis_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else begin
        m_axis_tready <= rst_n && ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // Watchdog: too long with no word moving on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("** weighted_index_selector_unit: FAILED **");
        $finish;
      end
    end
  end

  function automatic logic [IN_TDATA_W-1:0] item_word(input logic [Q16_W-1:0] w,
                                                      input logic share,
                                                      input logic [DRAW_W-1:0] draw,
                                                      input logic [ENTRY_W-1:0] idx);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[Q16_W-1:0]               = w;
    word[Q16_W]                   = share;
    word[Q16_W+1 +: DRAW_W]       = draw;
    word[Q16_W+1+DRAW_W +: ENTRY_W] = idx;
    return word;
  endfunction

  // Offer one word, with random idle cycles ahead of it, and wait for acceptance
  task automatic send_word(input logic [MODE_W-1:0] mode, input logic [IN_TDATA_W-1:0] word);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= mode;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (mode == MODE_ADD && adds_sent < WIS_CAPACITY) adds_sent++;
  endtask

  // Unused fields of each item carry random content
  task automatic send_add(input logic [Q16_W-1:0] w, input logic share);
    send_word(MODE_ADD, item_word(w, share, DRAW_W'($urandom_range(0, 127)),
                                  ENTRY_W'($urandom_range(0, 63))));
  endtask

  task automatic send_draw(input logic [DRAW_W-1:0] draw);
    send_word(MODE_DRAW, item_word(Q16_W'($urandom_range(0, 131071)),
                                   1'($urandom_range(0, 1)), draw,
                                   ENTRY_W'($urandom_range(0, 63))));
  endtask

  task automatic send_read(input logic [ENTRY_W-1:0] idx);
    send_word(MODE_READ, item_word(Q16_W'($urandom_range(0, 131071)),
                                   1'($urandom_range(0, 1)),
                                   DRAW_W'($urandom_range(0, 127)), idx));
  endtask

  // Small weights keep the remainder alive; the last two slots take one and above one
  task automatic send_random_add();
    logic [Q16_W-1:0] w;
    logic             share;
    int               r;
    r     = $urandom_range(0, 99);
    share = 1'b0;
    if (adds_sent >= WIS_CAPACITY) begin
      w     = Q16_W'($urandom_range(0, 131071));
      share = 1'($urandom_range(0, 1));
    end else if (adds_sent == WIS_CAPACITY - 2) begin
      w = Q16_W'(ONE_Q16);
    end else if (adds_sent == WIS_CAPACITY - 1) begin
      w = '1;
    end else if (adds_sent < WIDE_ADDS_FROM) begin
      share = (r < 15);
      w     = Q16_W'($urandom_range(0, SMALL_W_MAX));
    end else begin
      share = (r < 25);
      w     = (r < 60) ? Q16_W'($urandom_range(0, 131071))
                       : Q16_W'($urandom_range(0, SMALL_W_MAX));
    end
    send_add(w, share);
  endtask

  task automatic send_random_item();
    int r;
    int d;
    r = $urandom_range(0, 99);
    d = $urandom_range(0, 99);
    if (r < 6) begin
      send_random_add();
    end else if (r < 50) begin
      if (d < 5) send_draw('0);
      else if (d < 10) send_draw(DRAW_W'($urandom_range(65, 127)));
      else send_draw(DRAW_W'($urandom_range(1, 64)));
    end else if (r < 96) begin
      // mostly positions that hold an entry
      if (adds_sent > 0 && d < 70) send_read(ENTRY_W'($urandom_range(0, adds_sent - 1)));
      else send_read(ENTRY_W'($urandom_range(0, 63)));
    end else begin
      send_word(MODE_UNUSED, $urandom & 32'h7FFF_FFFF);
    end
  endtask

  // Lower valid and hold off until every owed result has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    rst_n         <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= MODE_ADD;
    snd_idle_pct  = 36;
    rcv_idle_pct  <= 58;
    adds_sent     = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: draws find nothing, reads are out of range
    send_draw(DRAW_W'(1));
    send_draw('0);
    send_read('0);
    send_read('1);
    send_word(MODE_UNUSED, 32'h7FFF_FFFF);
    // marker with the weight field at its top, read before any draw
    send_add('1, 1'b1);
    send_read('0);
    send_add('0, 1'b0);
    send_add(Q16_W'(1), 1'b0);
    send_add('0, 1'b1);
    send_read(ENTRY_W'(3));
    send_read(ENTRY_W'(4));           // index equal to the count
    // first draw resolves both markers
    send_draw('0);
    send_read('0);
    send_read(ENTRY_W'(3));
    send_draw(DRAW_W'(64));           // sum just under one: no match
    send_draw(DRAW_W'(63));
    send_draw(DRAW_W'(32));
    send_draw('1);
    // a marker added after resolution gets the last bit of remainder
    send_add(Q16_W'($urandom_range(0, 131071)), 1'b1);
    send_draw(DRAW_W'(1));
    send_read(ENTRY_W'(4));
    send_word(MODE_UNUSED, '0);

    // random phases with different idling on each side
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin snd_idle_pct = 36; rcv_idle_pct <= 58; end
        1: begin snd_idle_pct = 58; rcv_idle_pct <= 36; end
        default: begin snd_idle_pct = 0; rcv_idle_pct <= 0; end
      endcase
      wait_drained();
      repeat (PHASE_ITEMS) send_random_item();
    end

    // fill the table, then push against the full table
    while (adds_sent < WIS_CAPACITY) send_random_add();
    send_random_add();
    send_random_add();
    send_draw(DRAW_W'($urandom_range(1, 64)));
    send_read('1);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** weighted_index_selector_unit: PASSED **");
    end else begin
      $display("** weighted_index_selector_unit: FAILED **");
    end
    $finish;
  end

endmodule
